/* hw/rtl/prp_pkg.sv */
// Shared constants, a register index type and a saturating add for the projection pipeline.
package prp_pkg;

    localparam int POINT_WIDTH_DEF = 32;
    localparam int PIXEL_FRAC_DEF  = 8;

    localparam int Q_FRAC     = 28;
    localparam int DIV_STEPS  = 62;            // quotient bits below the saturation limit
    localparam int DIV_HEAD   = 64 - (DIV_STEPS - Q_FRAC);  // dividend bits seeded at once
    localparam int QMUL_LAT   = 5;
    localparam int QDIV_LAT   = DIV_STEPS + 3;

    localparam int PIX_W      = 24;
    localparam int PIX_MARGIN = 20;
    localparam int UV_FRAC    = 12;

    localparam logic [63:0]        LIM    = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LIM_S  = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q  = 64'sh0000_0000_1000_0000;

    typedef enum logic [2:0] {
        REG_FOCAL     = 3'd0,
        REG_PRINCIPAL = 3'd1,
        REG_K1_K2     = 3'd2,
        REG_K3_K4     = 3'd3,
        REG_K5_K6     = 3'd4,
        REG_P1_P2     = 3'd5,
        REG_IMAGE     = 3'd6,
        REG_DEPTH     = 3'd7
    } cfg_idx_t;

    // a + b, clipped to +-LIM
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > LIM_S)
            return $signed(LIM);
        else if (s < -LIM_S)
            return -$signed(LIM);
        else
            return s[63:0];
    endfunction

endpackage

/* hw/rtl/prp_delay.sv */
// Enabled delay line that keeps operands aligned across the pipeline.
module prp_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] line_reg [0:N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                line_reg[i] <= '0;
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
                line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[N-1];
endmodule

/* hw/rtl/prp_qmul.sv */
// Pipelined Q28 multiply: 32x32 partial products, truncation toward zero, saturation.
module prp_qmul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    import prp_pkg::*;

    logic [63:0] ua_reg, ub_reg;
    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [33:0] mid_reg;
    logic [63:0] hip_reg;
    logic [31:0] lo32_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [63:0] m_next;
    logic signed [63:0] p_reg;

    always_comb
    begin
        if (hi_reg[63:Q_FRAC] != '0)
            m_next = LIM;
        else
            m_next = {hi_reg[Q_FRAC-1:0], lo_reg[63:Q_FRAC]};
        if (m_next > LIM)
            m_next = LIM;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes
            ua_reg   <= a[63] ? 64'd0 - a : a;
            ub_reg   <= b[63] ? 64'd0 - b : b;
            neg1_reg <= a[63] ^ b[63];
            // partial products
            p00_reg  <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg  <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg  <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg  <= ua_reg[63:32] * ub_reg[63:32];
            neg2_reg <= neg1_reg;
            // column sums
            mid_reg  <= 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
            hip_reg  <= p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]);
            lo32_reg <= p00_reg[31:0];
            neg3_reg <= neg2_reg;
            // full 128-bit product
            hi_reg   <= hip_reg + 64'(mid_reg[33:32]);
            lo_reg   <= {mid_reg[31:0], lo32_reg};
            neg4_reg <= neg3_reg;
            // shift, clip, sign
            p_reg    <= neg4_reg ? -$signed(m_next) : $signed(m_next);
        end
    end

    assign p = p_reg;
endmodule

/* hw/rtl/prp_qdiv.sv */
// Pipelined Q28 divide, one restoring step per stage, truncation toward zero, saturation.
module prp_qdiv (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] quo
);
    import prp_pkg::*;

    typedef struct packed {
        logic [63:0]          rem;
        logic [DIV_STEPS-1:0] dbits;
        logic [DIV_STEPS-1:0] q;
        logic [63:0]          ub;
        logic                 neg;
        logic                 sat;
        logic                 zero;
    } div_stage_t;

    logic [63:0]        ua_reg, ub_reg;
    logic               neg_reg;
    div_stage_t         stage_reg [0:DIV_STEPS];
    logic [63:0]        m_next;
    logic signed [63:0] quo_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg  <= num[63] ? 64'd0 - num : num;
            ub_reg  <= den[63] ? 64'd0 - den : den;
            neg_reg <= num[63] ^ den[63];
            // quotient would reach 2^62: clip
            stage_reg[0].sat   <= {34'd0, ua_reg} >= {ub_reg, 34'd0};
            stage_reg[0].zero  <= ub_reg == '0;
            stage_reg[0].rem   <= 64'(ua_reg[63:64-DIV_HEAD]);
            stage_reg[0].dbits <= {ua_reg[63-DIV_HEAD:0], {Q_FRAC{1'b0}}};
            stage_reg[0].q     <= '0;
            stage_reg[0].ub    <= ub_reg;
            stage_reg[0].neg   <= neg_reg;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [64:0] trial;
        logic        ge;
        logic [64:0] diff;

        assign trial = {stage_reg[i].rem, stage_reg[i].dbits[DIV_STEPS-1]};
        assign ge    = trial >= {1'b0, stage_reg[i].ub};
        assign diff  = trial - {1'b0, stage_reg[i].ub};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[i+1].rem   <= ge ? diff[63:0] : trial[63:0];
                stage_reg[i+1].dbits <= {stage_reg[i].dbits[DIV_STEPS-2:0], 1'b0};
                stage_reg[i+1].q     <= {stage_reg[i].q[DIV_STEPS-2:0], ge};
                stage_reg[i+1].ub    <= stage_reg[i].ub;
                stage_reg[i+1].neg   <= stage_reg[i].neg;
                stage_reg[i+1].sat   <= stage_reg[i].sat;
                stage_reg[i+1].zero  <= stage_reg[i].zero;
            end
        end
    end

    always_comb
    begin
        if (stage_reg[DIV_STEPS].zero)
            m_next = '0;
        else if (stage_reg[DIV_STEPS].sat)
            m_next = LIM;
        else
            m_next = 64'(stage_reg[DIV_STEPS].q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= stage_reg[DIV_STEPS].neg ? -$signed(m_next) : $signed(m_next);
    end

    assign quo = quo_reg;
endmodule

/* hw/rtl/pinhole_rational_projection.sv */
// Top level: pinhole projection with rational radial and tangential distortion.
// Pipeline depth is set by the two 65-stage dividers in series (x/z and y/z, then num/den)
//   and six 5-stage multiplies, from input transfer to result in the output register.
// Throughput: one point per cycle; the whole pipeline advances while the output skid is empty.
// Reset: clears all configuration registers to zero and every valid bit in the pipeline.
module pinhole_rational_projection #(
    parameter int POINT_WIDTH     = prp_pkg::POINT_WIDTH_DEF,
    parameter int PIXEL_FRAC_BITS = prp_pkg::PIXEL_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // point_x, point_y, point_z (POINT_WIDTH each), zero pad to bytes
    input  logic [((3*POINT_WIDTH+7)/8)*8-1:0]    s_tdata,
    input  logic                                  s_tlast,   // last_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_u [23:0], pixel_v [47:24]
    output logic [2*prp_pkg::PIX_W-1:0]           m_tdata,
    output logic                                  m_tuser,   // point_valid
    output logic                                  m_tlast,   // last_result
    input  logic                                  cfg_we,
    input  prp_pkg::cfg_idx_t                     cfg_addr,
    input  logic [63:0]                           cfg_wdata
);
    import prp_pkg::*;

    // Stage timing, counted from the input register (stage 0).
    localparam int QD  = QDIV_LAT;
    localparam int QM  = QMUL_LAT;
    localparam int T1  = QD;          // xn, yn
    localparam int T2  = T1 + QM;     // xx, yy, xy
    localparam int T3  = T2 + 1;      // r2, 2xx, 2yy
    localparam int T4  = T3 + 1;      // r2+2xx, r2+2yy
    localparam int T5  = T3 + QM;     // r4
    localparam int T6  = T5 + QM;     // r6
    localparam int T7  = T6 + QM;     // coefficient products
    localparam int T8  = T7 + 1;      // partial sums
    localparam int T9  = T8 + 1;      // num, den
    localparam int T10 = T9 + QD;     // radial factor
    localparam int T11 = T10 + QM;    // xn*rad, yn*rad
    localparam int T12 = T11 + 1;
    localparam int T13 = T12 + 1;     // xd, yd
    localparam int T14 = T13 + QM;    // fx*xd, fy*yd
    localparam int T15 = T14 + 1;     // u, v
    localparam int TT  = T2 + QM + 1; // doubled p*xy terms
    localparam int TP  = T4 + QM;     // p*(r2+2xx) terms

    localparam int PX_SHR = (PIXEL_FRAC_BITS <= UV_FRAC) ? UV_FRAC - PIXEL_FRAC_BITS : 0;
    localparam int PX_SHL = (PIXEL_FRAC_BITS >  UV_FRAC) ? PIXEL_FRAC_BITS - UV_FRAC : 0;
    localparam logic [PIX_W-1:0] PIX_BAD = PIX_W'((1 << PIX_W) - (1 << PIXEL_FRAC_BITS));
    localparam logic signed [63:0] LOW_BOUND = -64'sd81920;  // -20 px in Q12

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             depth_ok;
    } side_t;

    typedef struct packed {
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] u;
        logic             ok;
        logic             last;
    } result_t;

    // ---------------- configuration ----------------
    logic [63:0] focal_reg, principal_reg, k12_reg, k34_reg, k56_reg, p12_reg, depth_reg;
    logic [31:0] image_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= '0;
            principal_reg <= '0;
            k12_reg       <= '0;
            k34_reg       <= '0;
            k56_reg       <= '0;
            p12_reg       <= '0;
            image_reg     <= '0;
            depth_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FOCAL:     focal_reg     <= cfg_wdata;
                REG_PRINCIPAL: principal_reg <= cfg_wdata;
                REG_K1_K2:     k12_reg       <= cfg_wdata;
                REG_K3_K4:     k34_reg       <= cfg_wdata;
                REG_K5_K6:     k56_reg       <= cfg_wdata;
                REG_P1_P2:     p12_reg       <= cfg_wdata;
                REG_IMAGE:     image_reg     <= cfg_wdata[31:0];
                REG_DEPTH:     depth_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficients widened to the 64-bit Q28 working format.
    logic signed [63:0] k1, k2, k3, k4, k5, k6, p1, p2, fx, fy, cx, cy, near_z, far_z;
    logic [15:0]        img_w, img_h;

    assign k1     = 64'($signed(k12_reg[63:32]));
    assign k2     = 64'($signed(k12_reg[31:0]));
    assign k3     = 64'($signed(k34_reg[63:32]));
    assign k4     = 64'($signed(k34_reg[31:0]));
    assign k5     = 64'($signed(k56_reg[63:32]));
    assign k6     = 64'($signed(k56_reg[31:0]));
    assign p1     = 64'($signed(p12_reg[63:32]));
    assign p2     = 64'($signed(p12_reg[31:0]));
    assign fx     = $signed({32'd0, focal_reg[63:32]});
    assign fy     = $signed({32'd0, focal_reg[31:0]});
    assign cx     = $signed({32'd0, principal_reg[63:32]});
    assign cy     = $signed({32'd0, principal_reg[31:0]});
    assign near_z = 64'($signed(depth_reg[63:32]));
    assign far_z  = 64'($signed(depth_reg[31:0]));
    assign img_w  = image_reg[31:16];
    assign img_h  = image_reg[15:0];

    // ---------------- flow control ----------------
    // Every stage moves together; only a full skid entry holds the pipe.
    logic    skid_valid_reg, out_valid_reg;
    result_t skid_reg, out_reg;
    logic    en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage 0: input register, depth test ----------------
    logic signed [63:0] x_in, y_in, z_in;
    logic signed [63:0] x_reg, y_reg, z_reg;
    side_t              side0_reg, side15;

    assign x_in = 64'($signed(s_tdata[POINT_WIDTH-1:0]));
    assign y_in = 64'($signed(s_tdata[2*POINT_WIDTH-1:POINT_WIDTH]));
    assign z_in = 64'($signed(s_tdata[3*POINT_WIDTH-1:2*POINT_WIDTH]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side0_reg <= '0;
        else if (en)
        begin
            side0_reg.valid    <= s_tvalid;
            side0_reg.last     <= s_tlast;
            // strictly inside (near, far), and z = 0 is rejected
            side0_reg.depth_ok <= (z_in > near_z) && (z_in < far_z) && (z_in != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
    end

    prp_delay #(.W($bits(side_t)), .N(T15)) u_side_dly (
        .clk, .rst_n, .en, .d(side0_reg), .q(side15)
    );

    // ---------------- normalize by depth ----------------
    logic signed [63:0] xn, yn;

    prp_qdiv u_div_x (.clk, .en, .num(x_reg), .den(z_reg), .quo(xn));
    prp_qdiv u_div_y (.clk, .en, .num(y_reg), .den(z_reg), .quo(yn));

    // ---------------- squares ----------------
    logic signed [63:0] xx, yy, xy;
    logic signed [63:0] r2_reg, xx2_reg, yy2_reg, ax_reg, ay_reg;

    prp_qmul u_mul_xx (.clk, .en, .a(xn), .b(xn), .p(xx));
    prp_qmul u_mul_yy (.clk, .en, .a(yn), .b(yn), .p(yy));
    prp_qmul u_mul_xy (.clk, .en, .a(xn), .b(yn), .p(xy));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= sadd(xx, yy);
            xx2_reg <= sadd(xx, xx);
            yy2_reg <= sadd(yy, yy);
            ax_reg  <= sadd(r2_reg, xx2_reg);
            ay_reg  <= sadd(r2_reg, yy2_reg);
        end
    end

    // ---------------- tangential terms ----------------
    logic signed [63:0] t1, t2, tpx, tpy;
    logic signed [63:0] tt1_reg, tt2_reg;
    logic [63:0]        tt1_d, tt2_d, tpx_d, tpy_d;

    prp_qmul u_mul_t1  (.clk, .en, .a(p1), .b(xy),     .p(t1));
    prp_qmul u_mul_t2  (.clk, .en, .a(p2), .b(xy),     .p(t2));
    prp_qmul u_mul_tpx (.clk, .en, .a(p2), .b(ax_reg), .p(tpx));
    prp_qmul u_mul_tpy (.clk, .en, .a(p1), .b(ay_reg), .p(tpy));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt1_reg <= sadd(t1, t1);
            tt2_reg <= sadd(t2, t2);
        end
    end

    prp_delay #(.W(64), .N(T11 - TT)) u_tt1_dly (.clk, .rst_n, .en, .d(tt1_reg), .q(tt1_d));
    prp_delay #(.W(64), .N(T12 - TT)) u_tt2_dly (.clk, .rst_n, .en, .d(tt2_reg), .q(tt2_d));
    prp_delay #(.W(64), .N(T12 - TP)) u_tpx_dly (.clk, .rst_n, .en, .d(tpx), .q(tpx_d));
    prp_delay #(.W(64), .N(T11 - TP)) u_tpy_dly (.clk, .rst_n, .en, .d(tpy), .q(tpy_d));

    // ---------------- radial powers ----------------
    logic signed [63:0] r4, r6;
    logic [63:0]        r2_d5, r2_d6, r4_d6;

    prp_delay #(.W(64), .N(T5 - T3)) u_r2a_dly (.clk, .rst_n, .en, .d(r2_reg), .q(r2_d5));
    prp_delay #(.W(64), .N(T6 - T3)) u_r2b_dly (.clk, .rst_n, .en, .d(r2_reg), .q(r2_d6));
    prp_delay #(.W(64), .N(T6 - T5)) u_r4_dly  (.clk, .rst_n, .en, .d(r4),     .q(r4_d6));

    prp_qmul u_mul_r4 (.clk, .en, .a(r2_reg),          .b(r2_reg), .p(r4));
    prp_qmul u_mul_r6 (.clk, .en, .a($signed(r2_d5)),  .b(r4),     .p(r6));

    // ---------------- rational radial factor ----------------
    logic signed [63:0] k1r2, k2r4, k3r6, k4r2, k5r4, k6r6;
    logic signed [63:0] na_reg, nb_reg, da_reg, db_reg, num_reg, den_reg, den_sum;

    prp_qmul u_mul_k1 (.clk, .en, .a(k1), .b($signed(r2_d6)), .p(k1r2));
    prp_qmul u_mul_k2 (.clk, .en, .a(k2), .b($signed(r4_d6)), .p(k2r4));
    prp_qmul u_mul_k3 (.clk, .en, .a(k3), .b(r6),             .p(k3r6));
    prp_qmul u_mul_k4 (.clk, .en, .a(k4), .b($signed(r2_d6)), .p(k4r2));
    prp_qmul u_mul_k5 (.clk, .en, .a(k5), .b($signed(r4_d6)), .p(k5r4));
    prp_qmul u_mul_k6 (.clk, .en, .a(k6), .b(r6),             .p(k6r6));

    assign den_sum = sadd(da_reg, db_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg  <= sadd(ONE_Q, k1r2);
            nb_reg  <= sadd(k2r4, k3r6);
            da_reg  <= sadd(ONE_Q, k4r2);
            db_reg  <= sadd(k5r4, k6r6);
            num_reg <= sadd(na_reg, nb_reg);
            // denominator floor: one LSB
            den_reg <= (den_sum < 64'sd1) ? 64'sd1 : den_sum;
        end
    end

    logic signed [63:0] rad;
    logic [127:0]       xnyn_d;

    prp_qdiv u_div_rad (.clk, .en, .num(num_reg), .den(den_reg), .quo(rad));

    prp_delay #(.W(128), .N(T10 - T1)) u_xnyn_dly (
        .clk, .rst_n, .en, .d({xn, yn}), .q(xnyn_d)
    );

    // ---------------- distorted coordinates ----------------
    logic signed [63:0] xr, yr;
    logic signed [63:0] xa_reg, ya_reg, xd_reg, yd_reg;

    prp_qmul u_mul_xr (.clk, .en, .a($signed(xnyn_d[127:64])), .b(rad), .p(xr));
    prp_qmul u_mul_yr (.clk, .en, .a($signed(xnyn_d[63:0])),   .b(rad), .p(yr));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg <= sadd(xr, $signed(tt1_d));
            ya_reg <= sadd(yr, $signed(tpy_d));
            xd_reg <= sadd(xa_reg, $signed(tpx_d));
            yd_reg <= sadd(ya_reg, $signed(tt2_d));
        end
    end

    // ---------------- intrinsics (results in Q12) ----------------
    logic signed [63:0] mu, mv, u_reg, v_reg;

    prp_qmul u_mul_fx (.clk, .en, .a(fx), .b(xd_reg), .p(mu));
    prp_qmul u_mul_fy (.clk, .en, .a(fy), .b(yd_reg), .p(mv));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= sadd(mu, cx);
            v_reg <= sadd(mv, cy);
        end
    end

    // ---------------- bounds, clamp, output format ----------------
    // Clamp to [0, (size-1) px]; a zero size pins the coordinate to 0.
    function automatic logic [PIX_W-1:0] pix_conv(input logic signed [63:0] p,
                                                   input logic [15:0] size);
        logic signed [63:0] top;
        logic signed [63:0] c;
        logic [32:0]        sh;
        top = $signed({36'd0, size, 12'd0}) - 64'sd4096;
        c   = (p > top) ? top : p;
        if (c < 0)
            c = '0;
        sh  = (33'(c[28:0]) >> PX_SHR) << PX_SHL;
        return (sh > 33'h7F_FFFF) ? PIX_W'(24'h7F_FFFF) : sh[PIX_W-1:0];
    endfunction

    logic signed [63:0] u_high, v_high;
    logic               in_view;
    result_t            res;

    assign u_high  = $signed({35'd0, 17'(img_w) + 17'd20, 12'd0});
    assign v_high  = $signed({35'd0, 17'(img_h) + 17'd20, 12'd0});
    assign in_view = side15.depth_ok
                  && (u_reg >= LOW_BOUND) && (u_reg < u_high)
                  && (v_reg >= LOW_BOUND) && (v_reg < v_high);

    always_comb
    begin
        res.last = side15.last;
        res.ok   = in_view;
        if (in_view)
        begin
            res.u = pix_conv(u_reg, img_w);
            res.v = pix_conv(v_reg, img_h);
        end
        else
        begin
            res.u = PIX_BAD;
            res.v = PIX_BAD;
        end
    end

    // ---------------- output register with skid entry ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= side15.valid;
            else if (side15.valid)
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (!out_valid_reg || m_tready)
                out_reg <= res;
            else
                skid_reg <= res;
        end
        else if (m_tready)
            out_reg <= skid_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.v, out_reg.u};
    assign m_tuser  = out_reg.ok;
    assign m_tlast  = out_reg.last;
endmodule
